>>> rtl/core/mlfs_pkg.sv
// Package for the monochrome LCD framebuffer scan-out block.
// Holds request codes, display command bytes, geometry constants and shared types.
// No dependencies.
`default_nettype none

package mlfs_pkg;

  localparam int unsigned SCREEN_WIDTH  = 128;
  localparam int unsigned SCREEN_HEIGHT = 64;

  localparam int unsigned ADDR_W  = 9;   // 512 store words
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned ROW_W   = 5;   // 32 half-screen rows
  localparam int unsigned SLOT_W  = 6;   // 34 slots per row
  localparam logic [SLOT_W-1:0] SLOT_LAST = 6'd33;
  localparam logic [ROW_W-1:0]  ROW_LAST  = 5'd31;

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_GET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_SCAN  = 2'd3
  } req_t;

  localparam logic [7:0] CMD_BEGIN = 8'h36;
  localparam logic [7:0] CMD_ADDR  = 8'h80;
  localparam logic [7:0] CMD_END   = 8'h32;
  localparam logic [7:0] CMD_CLEAR = 8'h01;

  // What the scan sequencer says about the current stream position.
  typedef struct packed {
    logic              is_data;     // byte comes from the store
    logic              hi_byte;     // high byte of the word when is_data
    logic [ADDR_W-1:0] addr;        // store word for a data byte
    logic [7:0]        cmd_byte;    // command byte when not is_data
    logic              last;        // final byte of the pass
  } scan_info_t;

endpackage

`default_nettype wire

>>> rtl/core/mlfs_store.sv
// Frame store: 512 x 16 synchronous memory, one write and one registered read port.
// Depends on mlfs_pkg.
`default_nettype none

module mlfs_store
  import mlfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mlfs_scan.sv
// Scan-out sequencer: tracks the position in the 1090-byte stream.
// Depends on mlfs_pkg.
`default_nettype none

module mlfs_scan
  import mlfs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic advance,
  output      scan_info_t info
);

  typedef enum logic [2:0] {
    SEG_BEGIN = 3'b001,
    SEG_BODY  = 3'b010,
    SEG_END   = 3'b100
  } seg_t;

  seg_t              seg_r, seg_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [4:0]        data_idx;

  // Data slots start at two; the byte index within the row drives column and half.
  assign data_idx = 5'(slot_r - SLOT_W'(2));

  always_comb begin
    info.is_data  = 1'b0;
    info.hi_byte  = ~data_idx[0];
    info.addr     = {data_idx[4:1], row_r};
    info.cmd_byte = CMD_BEGIN;
    info.last     = 1'b0;
    unique case (seg_r)
      SEG_BEGIN: info.cmd_byte = CMD_BEGIN;
      SEG_END: begin
        info.cmd_byte = CMD_END;
        info.last     = 1'b1;
      end
      SEG_BODY: begin
        if (slot_r == SLOT_W'(0)) begin
          info.cmd_byte = CMD_ADDR + {3'b000, row_r};
        end else if (slot_r == SLOT_W'(1)) begin
          info.cmd_byte = CMD_ADDR;
        end else begin
          info.is_data = 1'b1;
        end
      end
      default: info.cmd_byte = CMD_BEGIN;
    endcase
  end

  always_comb begin
    seg_nxt  = seg_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (advance) begin
      unique case (seg_r)
        SEG_BEGIN: begin
          seg_nxt  = SEG_BODY;
          row_nxt  = '0;
          slot_nxt = '0;
        end
        SEG_BODY: begin
          if (slot_r == SLOT_LAST) begin
            slot_nxt = '0;
            if (row_r == ROW_LAST) begin
              seg_nxt = SEG_END;
            end else begin
              row_nxt = row_r + ROW_W'(1);
            end
          end else begin
            slot_nxt = slot_r + SLOT_W'(1);
          end
        end
        SEG_END: seg_nxt = SEG_BEGIN;
        default: seg_nxt = SEG_BEGIN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= SEG_BEGIN;
      row_r  <= '0;
      slot_r <= '0;
    end else begin
      seg_r  <= seg_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mono_lcd_framebuffer_scanout.sv
// Top level of the monochrome LCD framebuffer scan-out block.
// Depends on mlfs_pkg, mlfs_store and mlfs_scan.
//
// Usage: each request on the in_ channel (valid/ready) sets a pixel, reads a
// pixel, clears the screen or asks for the next byte of the display scan-out
// stream. Every request produces exactly one result on the out_ channel.
// Pixel (x, y) lives in store word {y[5], x[6:4], y[4:0]}, MSB leftmost.
//
// Request flow: a request is taken in the idle state, the store word it
// needs is read in that same cycle, and the result is registered in the read
// stage once the output register is free; this pacing is set by the read-modify-write
// through the single store read port. A new set, get or scan request is taken
// only after the previous one has left the read stage. A clear request
// sweeps all 512 store words, one per cycle, then forms its result (command 0x01).
//
// Reset: rst_n is synchronous and active low. After reset the block runs the
// same clearing pass over all 512 store words, with in_ready low, and the
// scan position returns to the start of the stream.
//
// Stalls: the result waits in an output register while out_ready is low. A new
// request is still taken behind it; that request then holds in the read stage
// (its word stays in the store read register) until the output frees up.
`default_nettype none

module mono_lcd_framebuffer_scanout
  import mlfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic [7:0] in_pos_x,
  input  wire logic [6:0] in_pos_y,
  input  wire logic       in_pixel_color,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic       out_pixel_value,
  output      logic       out_byte_valid,
  output      logic [7:0] out_byte_value,
  output      logic       out_byte_is_command,
  output      logic       out_stream_end
);

  // Control states: clearing sweep, waiting for a request, and the stage where
  // the store word is back and the result is formed.
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clr_emit_r, clr_emit_nxt;

  // Request held for the read stage.
  req_t              req_r;
  logic [7:0]        x_r;
  logic [6:0]        y_r;
  logic              color_r;
  scan_info_t        scan_hold_r;

  logic              in_fire, out_free, finish;
  logic              in_range;
  scan_info_t        scan_info;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;
  logic [WORD_W-1:0] bit_mask;

  logic              out_valid_r;
  logic              pix_r, bval_r, bcmd_r, bend_r;
  logic [7:0]        byte_r;
  logic              pix_nxt, bval_nxt, bcmd_nxt, bend_nxt;
  logic [7:0]        byte_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign finish    = (state_r == S_READ) && out_free;

  assign in_range  = (x_r < 8'(SCREEN_WIDTH)) && (y_r < 7'(SCREEN_HEIGHT));
  assign bit_mask  = 16'h8000 >> x_r[3:0];

  // Store read: pixel word from the request coordinates, or the scan word.
  assign mem_re    = in_fire;
  assign mem_raddr = (req_t'(in_req_type) == REQ_SCAN) ?
                     scan_info.addr : {in_pos_y[5], in_pos_x[6:4], in_pos_y[4:0]};

  // Store write: the clearing sweep, or the write-back of a pixel set. The
  // next read is issued no earlier than the idle cycle after the write, so no
  // forwarding is needed.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (finish && (req_r == REQ_SET) && in_range) begin
      mem_we    = 1'b1;
      mem_waddr = {y_r[5], x_r[6:4], y_r[4:0]};
      mem_wdata = color_r ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
    end
  end

  mlfs_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mlfs_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (finish && (req_r == REQ_SCAN)),
    .info    (scan_info)
  );

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_emit_nxt = clr_emit_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = clr_emit_r ? S_READ : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (req_t'(in_req_type) == REQ_CLEAR) begin
            state_nxt    = S_CLEAR;
            clr_cnt_nxt  = '0;
            clr_emit_nxt = 1'b1;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      clr_emit_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      clr_emit_r <= clr_emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r       <= req_t'(in_req_type);
      x_r         <= in_pos_x;
      y_r         <= in_pos_y;
      color_r     <= in_pixel_color;
      scan_hold_r <= scan_info;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result fields formed from the held request and the store word.
  always_comb begin
    pix_nxt  = 1'b0;
    bval_nxt = 1'b0;
    byte_nxt = '0;
    bcmd_nxt = 1'b0;
    bend_nxt = 1'b0;
    unique case (req_r)
      REQ_SET: ;
      REQ_GET: pix_nxt = in_range && ((mem_rdata & bit_mask) != '0);
      REQ_CLEAR: begin
        bval_nxt = 1'b1;
        byte_nxt = CMD_CLEAR;
        bcmd_nxt = 1'b1;
      end
      REQ_SCAN: begin
        bval_nxt = 1'b1;
        bend_nxt = scan_hold_r.last;
        if (scan_hold_r.is_data) begin
          byte_nxt = scan_hold_r.hi_byte ? mem_rdata[15:8] : mem_rdata[7:0];
        end else begin
          byte_nxt = scan_hold_r.cmd_byte;
          bcmd_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      pix_r  <= pix_nxt;
      bval_r <= bval_nxt;
      byte_r <= byte_nxt;
      bcmd_r <= bcmd_nxt;
      bend_r <= bend_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_value     = pix_r;
  assign out_byte_valid      = bval_r;
  assign out_byte_value      = byte_r;
  assign out_byte_is_command = bcmd_r;
  assign out_stream_end      = bend_r;

  // The store is only written during the sweep or on leaving the read stage.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  // An accepted request always moves on to the read stage or the sweep.
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_READ || state_r == S_CLEAR))
    else $error("accepted request did not advance");

  // The end-of-pass flag only rides on the final command byte.
  a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stream_end) |->
      (out_byte_is_command && out_byte_valid && out_byte_value == CMD_END))
    else $error("stream end on wrong byte");

  // A result is never formed while the previous one is still blocked.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && state_r == S_READ) |=> (state_r == S_READ))
    else $error("read stage left while output stalled");

endmodule

`default_nettype wire

>>> tb/mlfs_checker.sv
// Checker for the monochrome LCD framebuffer scan-out block: watches both channels,
// predicts every result from a shadow copy of the store and scan position.
// Depends on mlfs_pkg.
`default_nettype none

module mlfs_checker
  import mlfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic [7:0] in_pos_x,
  input  wire logic [6:0] in_pos_y,
  input  wire logic       in_pixel_color,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic       out_pixel_value,
  input  wire logic       out_byte_valid,
  input  wire logic [7:0] out_byte_value,
  input  wire logic       out_byte_is_command,
  input  wire logic       out_stream_end,
  output int              fail_count,
  output int              pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HALF_ROWS   = 32;
  localparam int unsigned ROW_SLOTS   = 34;
  localparam int unsigned STREAM_LAST = 1089;

  typedef struct packed {
    logic       pixel_value;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       byte_is_command;
    logic       stream_end;
  } link_result_t;

  logic [WORD_W-1:0] shadow_words [512];
  logic [10:0]       shadow_scan_pos;
  link_result_t      awaited_results [$];
  int                mismatch_total = 0;

  function automatic int unsigned store_addr(logic [7:0] x, logic [6:0] y);
    int unsigned col;
    col = x / 16 + 8 * (y / HALF_ROWS);
    return (col * HALF_ROWS + y % HALF_ROWS) & 511;
  endfunction

  // Applies one request to the shadow state and returns the result it should produce.
  function automatic link_result_t predict_link_result(req_t kind, logic [7:0] x,
                                                       logic [6:0] y, logic color);
    link_result_t res;
    logic         in_range;
    int unsigned  idx, q, row, slot, d, col;
    logic [15:0]  mask, w;
    res      = '0;
    in_range = (x < SCREEN_WIDTH) && (y < SCREEN_HEIGHT);
    idx      = store_addr(x, y);
    mask     = 16'h8000 >> x[3:0];
    case (kind)
      REQ_SET: begin
        if (in_range) begin
          if (color) shadow_words[idx] = shadow_words[idx] | mask;
          else       shadow_words[idx] = shadow_words[idx] & ~mask;
        end
      end
      REQ_GET: begin
        if (in_range) res.pixel_value = |(shadow_words[idx] & mask);
      end
      REQ_CLEAR: begin
        foreach (shadow_words[i]) shadow_words[i] = '0;
        res.byte_valid      = 1'b1;
        res.byte_value      = CMD_CLEAR;
        res.byte_is_command = 1'b1;
      end
      default: begin
        res.byte_valid = 1'b1;
        if (shadow_scan_pos == 0) begin
          res.byte_value      = CMD_BEGIN;
          res.byte_is_command = 1'b1;
        end else if (shadow_scan_pos >= STREAM_LAST) begin
          res.byte_value      = CMD_END;
          res.byte_is_command = 1'b1;
          res.stream_end      = 1'b1;
        end else begin
          q    = shadow_scan_pos - 1;
          row  = q / ROW_SLOTS;
          slot = q % ROW_SLOTS;
          if (slot == 0) begin
            res.byte_value      = CMD_ADDR + 8'(row);
            res.byte_is_command = 1'b1;
          end else if (slot == 1) begin
            res.byte_value      = CMD_ADDR;
            res.byte_is_command = 1'b1;
          end else begin
            d   = slot - 2;
            col = d / 2;
            w   = shadow_words[(col * HALF_ROWS + row) & 511];
            res.byte_value = d[0] ? w[7:0] : w[15:8];
          end
        end
        shadow_scan_pos = (shadow_scan_pos >= STREAM_LAST) ? 11'd0 : shadow_scan_pos + 11'd1;
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatch_total++;
    end
  endtask

  // Results are retired before new requests are queued, since a result never
  // belongs to a request taken at the same edge.
  always @(posedge clk) begin
    link_result_t got, want;
    if (!rst_n) begin
      foreach (shadow_words[i]) shadow_words[i] = '0;
      shadow_scan_pos = '0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_pixel_value, out_byte_valid, out_byte_value,
                out_byte_is_command, out_stream_end};
        if (awaited_results.size() == 0) begin
          $display("%0t ns: result with no request waiting, expected no result, actual 0x%0h",
                   $time, got);
          mismatch_total++;
        end else begin
          want = awaited_results.pop_front();
          check_field("pixel_value", want.pixel_value, got.pixel_value);
          check_field("byte_valid", want.byte_valid, got.byte_valid);
          check_field("byte_value", want.byte_value, got.byte_value);
          check_field("byte_is_command", want.byte_is_command, got.byte_is_command);
          check_field("stream_end", want.stream_end, got.stream_end);
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(predict_link_result(req_t'(in_req_type), in_pos_x,
                                                      in_pos_y, in_pixel_color));
    end
    fail_count    <= mismatch_total;
    pending_count <= awaited_results.size();
  end

endmodule

`default_nettype wire

>>> tb/mono_lcd_framebuffer_scanout_test.sv
// Top of the framebuffer scan-out testbench: clock, reset, request stimulus with
// random gaps and stalls, and the verdict. Depends on mlfs_pkg, the block and mlfs_checker.
`default_nettype none

module mono_lcd_framebuffer_scanout_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mlfs_pkg::*;

  localparam int MAX_GAP      = 18;

  logic       clk                 = 1'b0;
  logic       rst_n               = 1'b0;
  logic       in_valid            = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type         = REQ_GET;
  logic [7:0] in_pos_x            = '0;
  logic [6:0] in_pos_y            = '0;
  logic       in_pixel_color      = 1'b0;
  logic       out_valid;
  logic       out_ready           = 1'b0;
  logic       out_pixel_value;
  logic       out_byte_valid;
  logic [7:0] out_byte_value;
  logic       out_byte_is_command;
  logic       out_stream_end;

  int fail_count;
  int pending_count;

  // Sender bookkeeping. The quiet flags select stretches with no idling at all.
  int   requests_sent = 0;
  bit   in_quiet      = 1'b0;
  bit   out_quiet     = 1'b0;

  // Recently written pixels, so that later gets and scan bytes find set bits.
  logic [7:0] hot_x [8];
  logic [6:0] hot_y [8];
  int         hot_next = 0;

  mono_lcd_framebuffer_scanout u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_pixel_color      (in_pixel_color),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pixel_value     (out_pixel_value),
    .out_byte_valid      (out_byte_valid),
    .out_byte_value      (out_byte_value),
    .out_byte_is_command (out_byte_is_command),
    .out_stream_end      (out_stream_end)
  );

  mlfs_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_pixel_color      (in_pixel_color),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pixel_value     (out_pixel_value),
    .out_byte_valid      (out_byte_valid),
    .out_byte_value      (out_byte_value),
    .out_byte_is_command (out_byte_is_command),
    .out_stream_end      (out_stream_end),
    .fail_count          (fail_count),
    .pending_count       (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop. The slowest legal run, with every gap and stall at its longest and
  // all the clear sweeps, stays well under a fifth of this.
  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Presents one request and returns at the edge where it is accepted. A gap of
  // zero keeps in_valid high straight into the next request.
  task automatic send_request(req_t kind, logic [7:0] x, logic [6:0] y, logic color);
    int gap;
    if (requests_sent % 40 == 0) in_quiet = ($urandom_range(0, 3) == 0);
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_pixel_color <= color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // A set or get at a random pixel. Most coordinates are on screen, some reuse a
  // recently written pixel, and the rest span the full field range, which puts
  // many of them off screen.
  task automatic random_pixel_request(bit is_get);
    logic [7:0] x;
    logic [6:0] y;
    int         pick;
    int         slot;
    logic       color;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      x = 8'($urandom_range(0, 255));
      y = 7'($urandom_range(0, 127));
    end else if (pick < 40) begin
      slot = $urandom_range(0, 7);
      x = hot_x[slot];
      y = hot_y[slot];
    end else begin
      x = 8'($urandom_range(0, SCREEN_WIDTH - 1));
      y = 7'($urandom_range(0, SCREEN_HEIGHT - 1));
    end
    color = ($urandom_range(0, 9) < 7);
    if (is_get) begin
      send_request(REQ_GET, x, y, 1'($urandom_range(0, 1)));
    end else begin
      send_request(REQ_SET, x, y, color);
      if (x < SCREEN_WIDTH && y < SCREEN_HEIGHT) begin
        hot_x[hot_next] = x;
        hot_y[hot_next] = y;
        hot_next = (hot_next + 1) % 8;
      end
    end
  endtask

  // Result side: before each result the receiver holds out_ready low for a
  // random number of cycles, except in quiet stretches.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    forever begin
      if (taken % 40 == 0) out_quiet = ($urandom_range(0, 3) == 0);
      stall = draw_gap(out_quiet);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    int pick;
    foreach (hot_x[i]) begin
      hot_x[i] = 8'(i * 17);
      hot_y[i] = 7'(i * 9);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The block is busy with its clearing pass for a while after
    // reset; the first request simply waits for in_ready.
    send_request(REQ_GET, 8'd0, 7'd0, 1'b1);        // freshly reset store reads zero
    send_request(REQ_SET, 8'd0, 7'd0, 1'b1);        // top-left corner
    send_request(REQ_GET, 8'd0, 7'd0, 1'b0);
    send_request(REQ_SET, 8'd127, 7'd63, 1'b1);     // bottom-right corner
    send_request(REQ_GET, 8'd127, 7'd63, 1'b0);
    send_request(REQ_SET, 8'd15, 7'd0, 1'b1);       // last pixel of the first word
    send_request(REQ_SET, 8'd16, 7'd31, 1'b1);      // last row of the top half
    send_request(REQ_SET, 8'd0, 7'd32, 1'b1);       // first row of the bottom half
    send_request(REQ_SET, 8'd128, 7'd0, 1'b1);      // column just off screen
    send_request(REQ_GET, 8'd128, 7'd0, 1'b0);
    send_request(REQ_SET, 8'd0, 7'd64, 1'b1);       // row just off screen
    send_request(REQ_GET, 8'd0, 7'd64, 1'b0);
    send_request(REQ_SET, 8'd255, 7'd127, 1'b1);    // both coordinates at their maximum
    send_request(REQ_GET, 8'd255, 7'd127, 1'b1);
    send_request(REQ_SET, 8'd0, 7'd0, 1'b0);        // turning a pixel back off
    send_request(REQ_GET, 8'd0, 7'd0, 1'b0);
    // Start of the stream: begin command, row address, column address, first data.
    send_request(REQ_SCAN, 8'd0, 7'd0, 1'b0);
    send_request(REQ_SCAN, 8'd255, 7'd127, 1'b1);
    send_request(REQ_SCAN, 8'd0, 7'd0, 1'b0);
    send_request(REQ_SCAN, 8'd0, 7'd0, 1'b0);
    send_request(REQ_CLEAR, 8'd255, 7'd127, 1'b1);  // clear does not move the scan
    send_request(REQ_GET, 8'd127, 7'd63, 1'b0);
    send_request(REQ_SCAN, 8'd0, 7'd0, 1'b0);

    // Random part: pixel traffic interleaved with scan-out, and an occasional clear.
    repeat (827) begin
      pick = $urandom_range(0, 199);
      if (pick < 3)
        send_request(REQ_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                     1'($urandom_range(0, 1)));
      else if (pick < 110)
        send_request(REQ_SCAN, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                     1'($urandom_range(0, 1)));
      else
        random_pixel_request(pick >= 170);
    end
    in_valid <= 1'b0;

    // Drain every outstanding result, then leave room for any stray extra one.
    do @(posedge clk); while (pending_count != 0);
    repeat (40) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/mlfs_pkg.sv
rtl/core/mlfs_store.sv
rtl/core/mlfs_scan.sv
rtl/core/mono_lcd_framebuffer_scanout.sv
tb/mlfs_checker.sv
tb/mono_lcd_framebuffer_scanout_test.sv
